@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and defaults of the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int BLOCK_WIDTH_DEF = 32;
    localparam int BLOCK_PORT_W    = 32;
    localparam int MAX_BLOCK_W     = 64;
    localparam int KEY_W           = 32;
    localparam int COUNT_PORT_W    = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DESCENDING = 1'd0,
        REG_TIES_AFTER = 1'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        WR_NEW,
        WR_CARRY,
        WR_RDATA
    } t_wr_sel;

    typedef struct packed {
        logic    take;
        logic    pop_ok;
        logic    rd_en;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    carry_ld;
        logic    out_ld;
        logic    out_nonempty;
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// insertion sorted priority queue of blocks keyed by signed priority
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall) takes one transaction: push, pop or
// query; output channel (o_out_valid / i_out_stall) returns one result per
// transaction with status, popped block, front block, count and flags.
// entries sit in one ram with a single read and a single write port, and
// a push that is not full or a pop of more than one entry walks it one entry
// per cycle; a push walks every stored entry and one more slot, a pop shifts
// each entry behind the front one slot forward. query, push when full and pop
// when empty or of the last entry go straight to hand-off with no walk.
// a new transaction is accepted the cycle after the result is loaded.
// o_in_stall is high while a transaction is in work; a stalled result waits
// in the output register and holds the next transaction at hand-off.
// synchronous reset empties the queue and sets ascending order with ties
// placed after equal priorities; ram contents are not cleared.
// configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH       = spq_pkg::DEPTH_DEF,
    parameter int BLOCK_WIDTH = spq_pkg::BLOCK_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [spq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [spq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [spq_pkg::BLOCK_PORT_W-1:0]    i_block_value,
    input  wire logic signed [spq_pkg::KEY_W-1:0]    i_priority_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_status,
    output logic [spq_pkg::BLOCK_PORT_W-1:0]         o_popped_block,
    output logic [spq_pkg::BLOCK_PORT_W-1:0]         o_front_block,
    output logic [spq_pkg::COUNT_PORT_W-1:0]         o_entry_count,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);

    localparam int AW = $clog2(DEPTH);

    logic               r_descending;
    logic               r_ties_after;
    spq_pkg::t_cmd      cmd;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               goes_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
            r_ties_after <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                spq_pkg::REG_DESCENDING: r_descending <= i_cfg_data[0];
                spq_pkg::REG_TIES_AFTER: r_ties_after <= i_cfg_data[0];
                default: begin
                    r_descending <= r_descending;
                end
            endcase
        end
    end

    spq_controller #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_operation   (i_operation),
        .i_out_stall   (i_out_stall),
        .i_goes_after  (goes_after),
        .o_in_stall    (o_in_stall),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    spq_datapath #(
        .DEPTH       (DEPTH),
        .BLOCK_WIDTH (BLOCK_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_wr_addr      (wr_addr),
        .i_block_value  (i_block_value),
        .i_priority_req (i_priority_req),
        .i_descending   (r_descending),
        .i_ties_after   (r_ties_after),
        .o_goes_after   (goes_after),
        .o_popped_block (o_popped_block),
        .o_front_block  (o_front_block)
    );

endmodule

`default_nettype wire

@@ hdl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// entry ram, new entry and carry registers, front tracking and key compare
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
    parameter int DEPTH       = spq_pkg::DEPTH_DEF,
    parameter int BLOCK_WIDTH = spq_pkg::BLOCK_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire spq_pkg::t_cmd                     i_cmd,
    input  wire logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  wire logic [spq_pkg::BLOCK_PORT_W-1:0]  i_block_value,
    input  wire logic signed [spq_pkg::KEY_W-1:0]  i_priority_req,
    input  wire logic                              i_descending,
    input  wire logic                              i_ties_after,
    output logic                                   o_goes_after,
    output logic [spq_pkg::BLOCK_PORT_W-1:0]       o_popped_block,
    output logic [spq_pkg::BLOCK_PORT_W-1:0]       o_front_block
);

    localparam int AW = $clog2(DEPTH);
    localparam int KW = spq_pkg::KEY_W;
    localparam int EW = BLOCK_WIDTH + KW;

    logic [spq_pkg::MAX_BLOCK_W-1:0] in_blk_ext;
    logic [spq_pkg::MAX_BLOCK_W-1:0] front_ext;
    logic [spq_pkg::MAX_BLOCK_W-1:0] popped_ext;
    logic [BLOCK_WIDTH-1:0]          r_new_blk;
    logic signed [KW-1:0]            r_new_key;
    logic [EW-1:0]                   r_carry;
    logic [BLOCK_WIDTH-1:0]          r_front;
    logic [BLOCK_WIDTH-1:0]          r_popped;
    logic [spq_pkg::BLOCK_PORT_W-1:0] r_out_popped;
    logic [spq_pkg::BLOCK_PORT_W-1:0] r_out_front;
    logic [EW-1:0]                   rd_data;
    logic [EW-1:0]                   wr_data;
    logic signed [KW-1:0]            stored_key;

    assign in_blk_ext = spq_pkg::MAX_BLOCK_W'(i_block_value);

    always_comb begin
        case (i_cmd.wr_sel)
            spq_pkg::WR_NEW:   wr_data = {r_new_blk, r_new_key};
            spq_pkg::WR_CARRY: wr_data = r_carry;
            spq_pkg::WR_RDATA: wr_data = rd_data;
            default:           wr_data = rd_data;
        endcase
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    // new entry follows a better key, or an equal one when ties go after
    assign stored_key = $signed(rd_data[KW-1:0]);

    always_comb begin
        if (r_new_key == stored_key) begin
            o_goes_after = i_ties_after;
        end else if (i_descending) begin
            o_goes_after = stored_key > r_new_key;
        end else begin
            o_goes_after = stored_key < r_new_key;
        end
    end

    assign front_ext  = spq_pkg::MAX_BLOCK_W'(r_front);
    assign popped_ext = spq_pkg::MAX_BLOCK_W'(r_popped);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_new_blk <= in_blk_ext[BLOCK_WIDTH-1:0];
            r_new_key <= i_priority_req;
            r_popped  <= i_cmd.pop_ok ? r_front : '0;
        end
        if (i_cmd.carry_ld) begin
            r_carry <= rd_data;
        end
        if (i_cmd.wr_en && (i_wr_addr == AW'(0))) begin
            r_front <= wr_data[EW-1:KW];
        end
        if (i_cmd.out_ld) begin
            r_out_popped <= popped_ext[spq_pkg::BLOCK_PORT_W-1:0];
            r_out_front  <= i_cmd.out_nonempty ? front_ext[spq_pkg::BLOCK_PORT_W-1:0] : '0;
        end
    end

    assign o_popped_block = r_out_popped;
    assign o_front_block  = r_out_front;

endmodule

`default_nettype wire

@@ hdl/spq_controller.sv @@
// ----------------------------------------------------------------------------
// spq_controller
// transaction sequencer: sorted insert walk, pop shift walk, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module spq_controller #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic [1:0]                         i_operation,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_goes_after,
    output logic                                    o_in_stall,
    output spq_pkg::t_cmd                           o_cmd,
    output logic [$clog2(DEPTH)-1:0]                o_rd_addr,
    output logic [$clog2(DEPTH)-1:0]                o_wr_addr,
    output logic                                    o_out_valid,
    output logic [1:0]                              o_status,
    output logic [spq_pkg::COUNT_PORT_W-1:0]        o_entry_count,
    output logic                                    o_is_empty,
    output logic                                    o_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > spq_pkg::COUNT_PORT_W) ? CW : spq_pkg::COUNT_PORT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_DONE
    } t_state;

    t_state           r_state,      n_state;
    logic [AW-1:0]    r_idx,        n_idx;
    logic [CW-1:0]    r_count,      n_count;
    logic             r_ins,        n_ins;
    spq_pkg::t_status r_status,     n_status;
    logic             r_out_valid,  n_out_valid;
    spq_pkg::t_status r_out_status, n_out_status;
    logic [CW-1:0]    r_out_count,  n_out_count;
    logic             r_out_empty,  n_out_empty;
    logic             r_out_full,   n_out_full;

    logic             last;
    logic             ins_here;
    logic [XW-1:0]    count_ext;

    assign last     = (CW'(r_idx) == r_count);
    assign ins_here = !r_ins && (last || !i_goes_after);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_ins        = r_ins;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_full   = r_out_full;
        o_cmd        = '0;
        o_cmd.wr_sel = spq_pkg::WR_NEW;
        o_rd_addr    = r_idx + AW'(1);
        o_wr_addr    = r_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_idx      = '0;
                    n_ins      = 1'b0;
                    n_status   = spq_pkg::ST_OK;
                    n_state    = S_DONE;
                    case (i_operation)
                        spq_pkg::OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = spq_pkg::ST_FULL;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                o_rd_addr   = '0;
                                n_state     = S_PUSH;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                o_cmd.pop_ok = 1'b1;
                                n_count      = '0;
                            end else begin
                                o_cmd.pop_ok = 1'b1;
                                o_cmd.rd_en  = 1'b1;
                                o_rd_addr    = AW'(1);
                                n_idx        = AW'(1);
                                n_state      = S_POP;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.carry_ld = 1'b1;
                o_cmd.wr_en    = ins_here || r_ins;
                o_cmd.wr_sel   = ins_here ? spq_pkg::WR_NEW : spq_pkg::WR_CARRY;
                n_ins          = r_ins || ins_here;
                if (last) begin
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_POP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = spq_pkg::WR_RDATA;
                o_wr_addr    = r_idx - AW'(1);
                if (CW'(r_idx) == (r_count - CW'(1))) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_ld       = 1'b1;
                    o_cmd.out_nonempty = (r_count != '0);
                    n_out_valid        = 1'b1;
                    n_out_status       = r_status;
                    n_out_count        = r_count;
                    n_out_empty        = (r_count == '0);
                    n_out_full         = (r_count == CW'(DEPTH));
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_count      <= '0;
            r_ins        <= 1'b0;
            r_status     <= spq_pkg::ST_OK;
            r_out_valid  <= 1'b0;
            r_out_status <= spq_pkg::ST_OK;
            r_out_count  <= '0;
            r_out_empty  <= 1'b1;
            r_out_full   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_count      <= n_count;
            r_ins        <= n_ins;
            r_status     <= n_status;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_empty  <= n_out_empty;
            r_out_full   <= n_out_full;
        end
    end

    assign count_ext     = XW'(r_out_count);
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = count_ext[spq_pkg::COUNT_PORT_W-1:0];
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;

endmodule

`default_nettype wire

@@ hdl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// port level checks of the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [1:0]                       o_status,
    input  wire logic [spq_pkg::BLOCK_PORT_W-1:0] o_popped_block,
    input  wire logic [spq_pkg::BLOCK_PORT_W-1:0] o_front_block,
    input  wire logic                             o_is_empty,
    input  wire logic                             o_is_full
);

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_empty && o_is_full))
        else $error("queue reported empty and full together");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == spq_pkg::ST_EMPTY))
            |-> (o_is_empty && (o_popped_block == '0)))
        else $error("pop on empty queue with entries or a block");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == spq_pkg::ST_FULL)) |-> o_is_full)
        else $error("push dropped while queue not full");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_front_block == '0))
        else $error("front block non-zero on empty queue");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_status) && $stable(o_front_block)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_checker (.*);

`default_nettype wire

@@ sim/spq_tracker_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_tracker_pkg
// shadow copy of the sorted priority queue and its ordered result check
// ----------------------------------------------------------------------------
// the tracker mirrors the stored entries, the count and both sort settings.
// each accepted transaction is applied to the mirror at once and its result
// is queued; results leaving the block are compared with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_tracker_pkg;

    import spq_pkg::*;

    typedef struct {
        t_status                   status;
        logic [BLOCK_PORT_W-1:0]   popped_block;
        logic [BLOCK_PORT_W-1:0]   front_block;
        logic [COUNT_PORT_W-1:0]   entry_count;
        logic                      is_empty;
        logic                      is_full;
    } t_spq_result;

    class spq_tracker;

        logic [BLOCK_PORT_W-1:0]   blocks [DEPTH_DEF];
        logic signed [KEY_W-1:0]   keys   [DEPTH_DEF];
        int                        stored;
        bit                        descending;
        bit                        ties_after;
        t_spq_result               expected_q [$];
        int                        mismatches;

        function new();
            stored     = 0;
            descending = 1'b0;
            ties_after = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic data);
            case (idx)
                REG_DESCENDING: descending = data;
                REG_TIES_AFTER: ties_after = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // new key walks past a stored key that ranks ahead of it, or an equal one when ties go after
        function bit walks_past(logic signed [KEY_W-1:0] new_key,
                                logic signed [KEY_W-1:0] stored_key);
            if (new_key == stored_key)
                return ties_after;
            if (descending)
                return stored_key > new_key;
            return stored_key < new_key;
        endfunction

        function void note_transaction(logic [1:0] op, logic [BLOCK_PORT_W-1:0] blk,
                                       logic signed [KEY_W-1:0] key);
            t_spq_result r;
            int          pos;
            r.status       = ST_OK;
            r.popped_block = '0;
            if (op == OP_PUSH) begin
                if (stored >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < stored && walks_past(key, keys[pos]))
                        pos++;
                    for (int i = stored; i > pos; i--) begin
                        blocks[i] = blocks[i-1];
                        keys[i]   = keys[i-1];
                    end
                    blocks[pos] = blk;
                    keys[pos]   = key;
                    stored++;
                end
            end else if (op == OP_POP) begin
                if (stored == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_block = blocks[0];
                    for (int i = 1; i < stored; i++) begin
                        blocks[i-1] = blocks[i];
                        keys[i-1]   = keys[i];
                    end
                    stored--;
                end
            end
            r.front_block = (stored > 0) ? blocks[0] : '0;
            r.entry_count = stored[COUNT_PORT_W-1:0];
            r.is_empty    = (stored == 0);
            r.is_full     = (stored == DEPTH_DEF);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_spq_result got);
            t_spq_result want;
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.popped_block !== want.popped_block) begin
                $error("popped_block: expected %h, actual %h",
                       want.popped_block, got.popped_block);
                mismatches++;
            end
            if (got.front_block !== want.front_block) begin
                $error("front_block: expected %h, actual %h",
                       want.front_block, got.front_block);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %b, actual %b", want.is_empty, got.is_empty);
                mismatches++;
            end
            if (got.is_full !== want.is_full) begin
                $error("is_full: expected %b, actual %b", want.is_full, got.is_full);
                mismatches++;
            end
        endfunction

    endclass

endpackage

`default_nettype wire

@@ sim/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking testbench of the sorted priority queue
// ----------------------------------------------------------------------------
// a short directed run covers the empty error, the unused operation, key
// extremes and equal keys; random bursts of filling, draining and mixed
// traffic follow under all four sort settings, with idle and stall pressure
// on both channels. every result is checked against a shadow queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;
    import spq_tracker_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         SETTLE     = 24;
    localparam int         SEGMENTS   = 8;
    localparam int         SEG_ITEMS  = 242;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_mode;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [1:0]                 i_operation;
    logic [BLOCK_PORT_W-1:0]    i_block_value;
    logic signed [KEY_W-1:0]    i_priority_req;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [1:0]                 o_status;
    logic [BLOCK_PORT_W-1:0]    o_popped_block;
    logic [BLOCK_PORT_W-1:0]    o_front_block;
    logic [COUNT_PORT_W-1:0]    o_entry_count;
    logic                       o_is_empty;
    logic                       o_is_full;

    spq_tracker                 tracker;
    t_spq_result                observed;
    int                         idle_pct;
    int                         stall_pct;
    int                         quiet_cycles;

    sorted_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_block_value  (i_block_value),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_block (o_popped_block),
        .o_front_block  (o_front_block),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            observed.status       = t_status'(o_status);
            observed.popped_block = o_popped_block;
            observed.front_block  = o_front_block;
            observed.entry_count  = o_entry_count;
            observed.is_empty     = o_is_empty;
            observed.is_full      = o_is_full;
            tracker.check_result(observed);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sorted_priority_queue_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(logic [1:0] op, logic [BLOCK_PORT_W-1:0] blk,
                        logic signed [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_block_value  <= blk;
        i_priority_req <= key;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_transaction(op, blk, key);
    endtask

    // hold the sender until every outstanding transaction has returned
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_priority();
        case ($urandom_range(4))
            0: return $signed($urandom_range(4)) - 2;
            1: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [BLOCK_PORT_W-1:0] pick_block();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_op(t_mode mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  return (roll < 80) ? OP_PUSH : (roll < 90) ? OP_POP :
                               (roll < 95) ? OP_QUERY : OP_UNUSED;
            MODE_DRAIN: return (roll < 80) ? OP_POP : (roll < 90) ? OP_PUSH :
                               (roll < 95) ? OP_QUERY : OP_UNUSED;
            default:    return (roll < 45) ? OP_PUSH : (roll < 85) ? OP_POP :
                               (roll < 93) ? OP_QUERY : OP_UNUSED;
        endcase
    endfunction

    initial begin
        t_mode mode;
        int    burst_left;
        int    combo;
        tracker        = new();
        idle_pct       = 0;
        stall_pct      = 0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = REG_DESCENDING;
        i_cfg_data     = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_QUERY;
        i_block_value  = '0;
        i_priority_req = '0;
        mode           = MODE_FILL;
        burst_left     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // reset settings: ascending, equal keys queue behind
        send(OP_POP, 32'h1234_5678, 32'sd5);
        send(OP_QUERY, '1, -32'sd1);
        send(OP_UNUSED, '1, 32'sh7FFF_FFFF);
        send(OP_PUSH, '0, 32'sh8000_0000);
        send(OP_PUSH, '1, 32'sh7FFF_FFFF);
        send(OP_PUSH, 32'hAAAA_0001, 32'sd0);
        send(OP_PUSH, 32'h5555_0002, 32'sd0);
        send(OP_PUSH, 32'h0F0F_0003, -32'sd1);
        send(OP_PUSH, 32'hF0F0_0004, 32'sd1);
        send(OP_QUERY, '0, '0);
        send(OP_UNUSED, '0, '0);
        repeat (6) send(OP_POP, $urandom, $signed($urandom));
        send(OP_POP, '1, 32'sh8000_0000);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg / 2)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            combo = seg % 4;
            cfg_write(REG_DESCENDING, (combo == 1 || combo == 2));
            cfg_write(REG_TIES_AFTER, (combo < 2));
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (n == SEG_ITEMS / 2)
                    drain();
                if (burst_left == 0) begin
                    mode       = t_mode'($urandom_range(2));
                    burst_left = $urandom_range(40, 8);
                end
                burst_left--;
                send(pick_op(mode), pick_block(), pick_priority());
            end
        end

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("sorted_priority_queue_tb: PASS");
        else
            $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
